>>> rtl/aled_pkg.sv
package aled_pkg;

    localparam int unsigned SLOTS_PER_PIXEL = 24;
    localparam int unsigned CNT_W = $clog2(SLOTS_PER_PIXEL + 1);
    localparam logic [CNT_W-1:0] SLOT_LAST_DATA = CNT_W'(SLOTS_PER_PIXEL - 1);
    localparam logic [CNT_W-1:0] SLOT_RESET = CNT_W'(SLOTS_PER_PIXEL);

    localparam logic [15:0] DEFAULT_RESET_SLOTS = 16'd50;
    localparam logic [15:0] ROUND_BIAS = 16'd127;

    localparam logic [15:0] LED_COUNT_RST = 16'd1;
    localparam logic [7:0] BRIGHTNESS_RST = 8'd255;
    localparam logic [15:0] ZERO_HIGH_RST = 16'd1;
    localparam logic [15:0] ONE_HIGH_RST = 16'd2;
    localparam logic [15:0] RESET_SLOTS_RST = 16'd50;

    typedef enum logic [2:0] {
        REG_LED_COUNT = 3'd0,
        REG_BRIGHTNESS = 3'd1,
        REG_ZERO_HIGH = 3'd2,
        REG_ONE_HIGH = 3'd3,
        REG_RESET_SLOTS = 3'd4
    } cfg_idx_t;

    // settings the slot serializer needs
    typedef struct packed {
        logic [15:0] zero_high_count;
        logic [15:0] one_high_count;
        logic [15:0] reset_slot_count;
    } slot_cfg_t;

endpackage

>>> rtl/aled_if.sv
interface aled_pix_if;
    logic valid;
    logic ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface aled_slot_if;
    logic valid;
    logic ready;
    logic [15:0] compare_value;
    logic [15:0] repeat_count;
    logic is_reset;
    logic last;

    modport source (output valid, output compare_value, output repeat_count,
                    output is_reset, output last, input ready);
    modport sink (input valid, input compare_value, input repeat_count,
                  input is_reset, input last, output ready);
endinterface

interface aled_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/aled_lane.sv
module aled_lane (
    input  logic       clk,
    input  logic       load,
    input  logic [7:0] value,
    input  logic [7:0] brightness,
    output logic [7:0] scaled
);
    import aled_pkg::*;

    logic [15:0] prod_reg;
    logic [15:0] prod_next;
    logic [16:0] div_sum;

    assign prod_next = 16'(value * brightness) + ROUND_BIAS;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // x / 255 for x below 65535: (x + (x >> 8) + 1) >> 8
    assign div_sum = {1'b0, prod_reg} + {9'd0, prod_reg[15:8]} + 17'd1;
    assign scaled = div_sum[15:8];

endmodule

>>> rtl/aled_ser.sv
module aled_ser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  aled_pkg::slot_cfg_t   cfg,
    input  logic                  load_valid,
    input  logic [23:0]           load_grb,
    input  logic                  load_frame_end,
    output logic                  load_ready,
    aled_slot_if.source           slot
);
    import aled_pkg::*;

    logic            busy_reg, busy_next;
    logic [23:0]     shift_reg, shift_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic            fe_reg, fe_next;

    logic            ov_reg, ov_next;
    logic [15:0]     cmp_reg, cmp_next;
    logic [15:0]     rep_reg, rep_next;
    logic            rst_item_reg, rst_item_next;
    logic            last_reg, last_next;

    logic out_free;
    logic emit;
    logic is_rst_slot;
    logic item_last;
    logic done;

    assign out_free = !ov_reg || slot.ready;
    assign emit = busy_reg && out_free;
    assign is_rst_slot = (cnt_reg == SLOT_RESET);
    assign item_last = is_rst_slot || ((cnt_reg == SLOT_LAST_DATA) && !fe_reg);
    assign done = emit && item_last;
    assign load_ready = !busy_reg || done;

    always_comb
    begin
        busy_next = busy_reg;
        shift_next = shift_reg;
        cnt_next = cnt_reg;
        fe_next = fe_reg;
        ov_next = ov_reg;
        cmp_next = cmp_reg;
        rep_next = rep_reg;
        rst_item_next = rst_item_reg;
        last_next = last_reg;

        if (emit)
        begin
            ov_next = 1'b1;
            last_next = item_last;
            if (is_rst_slot)
            begin
                cmp_next = 16'd0;
                rep_next = (cfg.reset_slot_count == 16'd0) ? DEFAULT_RESET_SLOTS
                                                           : cfg.reset_slot_count;
                rst_item_next = 1'b1;
            end
            else
            begin
                cmp_next = shift_reg[23] ? cfg.one_high_count : cfg.zero_high_count;
                rep_next = 16'd1;
                rst_item_next = 1'b0;
            end
            shift_next = {shift_reg[22:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (slot.ready)
        begin
            ov_next = 1'b0;
        end

        if (done)
        begin
            busy_next = 1'b0;
        end

        if (load_valid && load_ready)
        begin
            busy_next = 1'b1;
            shift_next = load_grb;
            cnt_next = '0;
            fe_next = load_frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg <= ov_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        fe_reg <= fe_next;
        cmp_reg <= cmp_next;
        rep_reg <= rep_next;
        rst_item_reg <= rst_item_next;
        last_reg <= last_next;
    end

    assign slot.valid = ov_reg;
    assign slot.compare_value = cmp_reg;
    assign slot.repeat_count = rep_reg;
    assign slot.is_reset = rst_item_reg;
    assign slot.last = last_reg;

endmodule

>>> rtl/addressable_led_pwm_slot_encoder_top.sv
// Addressable LED slot encoder, GRB order, MSB first.
// pix: one RGB888 pixel per word. slot: one PWM compare word per slot,
// one_high_count for a one bit, zero_high_count for a zero bit; the last
// pixel of a frame (led_count pixels, zero counts as one) is followed by a
// reset word with compare 0, repeat_count reset_slot_count (zero means 50).
// cfg: register writes (index 0..4), always ready; write only while idle.
// Three brightness lanes scale R, G and B in parallel, (v*b+127)/255, with
// one register stage; the merged GRB word loads the slot serializer.
// A pixel's first slot word passes the lane, serializer shift and output
// registers. The serializer emits one slot word per cycle unless the slot
// receiver stalls: 24 per pixel, then a reset word at the end of a frame.
// The next pixel is held in the lane stage and its first slot follows the
// previous pixel's last slot directly. A stalled slot receiver holds the
// output word and stalls the serializer, then the lane stage, then pix.ready.
// Reset: registers return to led_count 1, brightness 255, zero/one counts
// 1/2, 50 reset slots; the pixel counter clears and no word is pending.
module addressable_led_pwm_slot_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    aled_pix_if.sink    pix,
    aled_slot_if.source slot,
    aled_cfg_if.sink    cfg
);
    import aled_pkg::*;

    logic [15:0] led_count_reg;
    logic [7:0]  brightness_reg;
    logic [15:0] zero_high_reg;
    logic [15:0] one_high_reg;
    logic [15:0] reset_slots_reg;
    logic [15:0] pixel_idx_reg, pixel_idx_next;
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_fe_reg;

    logic        in_take;
    logic        ser_ready;
    logic        frame_end;
    logic [15:0] limit;
    logic [7:0]  g_scaled, r_scaled, b_scaled;
    slot_cfg_t   ser_cfg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= LED_COUNT_RST;
            brightness_reg <= BRIGHTNESS_RST;
            zero_high_reg <= ZERO_HIGH_RST;
            one_high_reg <= ONE_HIGH_RST;
            reset_slots_reg <= RESET_SLOTS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_LED_COUNT:   led_count_reg <= cfg.data;
                REG_BRIGHTNESS:  brightness_reg <= cfg.data[7:0];
                REG_ZERO_HIGH:   zero_high_reg <= cfg.data;
                REG_ONE_HIGH:    one_high_reg <= cfg.data;
                REG_RESET_SLOTS: reset_slots_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // frame position is settled when the pixel is accepted
    assign limit = (led_count_reg == 16'd0) ? 16'd1 : led_count_reg;
    assign frame_end = ({1'b0, pixel_idx_reg} + 17'd1) >= {1'b0, limit};

    assign pix.ready = !s1_valid_reg || ser_ready;
    assign in_take = pix.valid && pix.ready;

    always_comb
    begin
        pixel_idx_next = pixel_idx_reg;
        s1_valid_next = s1_valid_reg;
        if (s1_valid_reg && ser_ready)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_take)
        begin
            s1_valid_next = 1'b1;
            pixel_idx_next = frame_end ? 16'd0 : pixel_idx_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_idx_reg <= 16'd0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pixel_idx_reg <= pixel_idx_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_fe_reg <= frame_end;
        end
    end

    aled_lane u_lane_g (
        .clk        (clk),
        .load       (in_take),
        .value      (pix.green),
        .brightness (brightness_reg),
        .scaled     (g_scaled)
    );

    aled_lane u_lane_r (
        .clk        (clk),
        .load       (in_take),
        .value      (pix.red),
        .brightness (brightness_reg),
        .scaled     (r_scaled)
    );

    aled_lane u_lane_b (
        .clk        (clk),
        .load       (in_take),
        .value      (pix.blue),
        .brightness (brightness_reg),
        .scaled     (b_scaled)
    );

    assign ser_cfg.zero_high_count = zero_high_reg;
    assign ser_cfg.one_high_count = one_high_reg;
    assign ser_cfg.reset_slot_count = reset_slots_reg;

    aled_ser u_ser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (ser_cfg),
        .load_valid     (s1_valid_reg),
        .load_grb       ({g_scaled, r_scaled, b_scaled}),
        .load_frame_end (s1_fe_reg),
        .load_ready     (ser_ready),
        .slot           (slot)
    );

endmodule
